// ===== rtl/core/njs_pkg.sv =====
// Shared types and constants of the non-preemptive job scheduler.
// Used by njs_ctrl, njs_datapath and nonpreemptive_job_scheduler; depends on nothing.
package njs_pkg;

	// Capacity of the job table.
	localparam int MAX_JOBS = 16;
	localparam int IDX_W    = $clog2(MAX_JOBS);
	localparam int CNT_W    = $clog2(MAX_JOBS + 1);

	localparam int TIME_W  = 24;
	localparam int ID_W    = 7;
	localparam int ARR_W   = 16;
	localparam int BURST_W = 16;
	localparam int PRIO_W  = 8;
	localparam int KEY_W   = 16;

	// Policy codes. The unused code falls back to first come first served.
	localparam logic [1:0] POL_FCFS = 2'd0;
	localparam logic [1:0] POL_SJF  = 2'd1;
	localparam logic [1:0] POL_PRIO = 2'd2;

	typedef struct packed {
		logic [ARR_W-1:0]   arrival_time;
		logic [BURST_W-1:0] burst_length;
		logic [PRIO_W-1:0]  job_priority;
		logic               last_job;
	} job_t;

	typedef struct packed {
		logic [TIME_W-1:0]  start_time;
		logic [ID_W-1:0]    job_id;
		logic [BURST_W-1:0] run_length;
		logic               last_entry;
	} sched_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_JUMP,
		ST_EMIT
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // store the incoming job if the table has room
		logic start_set;  // time to zero, clear done flags and result count
		logic scan_start; // begin a pass over the loaded jobs
		logic jump;       // move time to the earliest pending arrival
		logic emit;       // issue the chosen job as a result
		logic finish;     // empty the table after the final result
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_fin;   // the pass has finished, its results are settled
		logic found;      // the pass found a job that has arrived
		logic last_emit;  // the next result is the final one of the set
		logic out_busy;   // the result register holds a transaction not yet taken
	} dp_stat_t;

endpackage

// ===== rtl/core/njs_datapath.sv =====
// Datapath of the job scheduler: job table, scan pipeline, time and result register.
// Depends on njs_pkg; driven by the command struct of njs_ctrl.
module njs_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  njs_pkg::ctl_cmd_t cmd,
	output njs_pkg::dp_stat_t stat,
	input  njs_pkg::job_t     job,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_wdata,
	output logic              sched_valid,
	input  logic              sched_stall,
	output njs_pkg::sched_t   sched
);
	import njs_pkg::*;

	// Job table, read one entry per cycle during a pass.
	logic [ARR_W-1:0]   arr_mem   [MAX_JOBS];
	logic [BURST_W-1:0] burst_mem [MAX_JOBS];
	logic [PRIO_W-1:0]  prio_mem  [MAX_JOBS];

	logic [MAX_JOBS-1:0] done_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    emitted_q;
	logic [TIME_W-1:0]   time_q;
	logic [1:0]          policy_q;

	logic             scanning_q;
	logic [IDX_W-1:0] addr_q;
	logic             addr_last;

	logic               vld_s1;
	logic               last_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [ARR_W-1:0]   arr_s1;
	logic [BURST_W-1:0] burst_s1;
	logic [PRIO_W-1:0]  prio_s1;

	logic [KEY_W-1:0]   key_s1;
	logic               pend_s1;
	logic               ready_s1;

	logic               found_q;
	logic [KEY_W-1:0]   best_key_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [BURST_W-1:0] best_burst_q;
	logic               pend_have_q;
	logic [ARR_W-1:0]   pend_min_q;
	logic               scan_fin_q;

	logic   sched_valid_q;
	sched_t sched_q;

	assign addr_last = ({1'b0, addr_q} + CNT_W'(1)) == count_q;

	// Table writes and registered reads.
	always_ff @(posedge clk) begin
		if (cmd.load && (count_q < CNT_W'(MAX_JOBS))) begin
			arr_mem[count_q[IDX_W-1:0]]   <= job.arrival_time;
			burst_mem[count_q[IDX_W-1:0]] <= job.burst_length;
			prio_mem[count_q[IDX_W-1:0]]  <= job.job_priority;
		end
		arr_s1   <= arr_mem[addr_q];
		burst_s1 <= burst_mem[addr_q];
		prio_s1  <= prio_mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_FCFS;
		end else if (cfg_we) begin
			policy_q <= cfg_wdata;
		end
	end

	// Scan address counter and the control side of the read stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scanning_q <= 1'b0;
			addr_q     <= '0;
			vld_s1     <= 1'b0;
			last_s1    <= 1'b0;
			idx_s1     <= '0;
			scan_fin_q <= 1'b0;
		end else begin
			vld_s1     <= scanning_q && !cmd.scan_start;
			last_s1    <= addr_last;
			idx_s1     <= addr_q;
			scan_fin_q <= vld_s1 && last_s1;
			if (cmd.scan_start) begin
				scanning_q <= 1'b1;
				addr_q     <= '0;
			end else if (scanning_q) begin
				if (addr_last) begin
					scanning_q <= 1'b0;
				end else begin
					addr_q <= addr_q + IDX_W'(1);
				end
			end
		end
	end

	always_comb begin
		unique case (policy_q)
			POL_SJF:  key_s1 = burst_s1;
			POL_PRIO: key_s1 = KEY_W'(prio_s1);
			default:  key_s1 = arr_s1;
		endcase
	end

	assign pend_s1  = vld_s1 && !done_q[idx_s1];
	assign ready_s1 = pend_s1 && (TIME_W'(arr_s1) <= time_q);

	// Running minimum over one pass; strict compare keeps the lower id on ties.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q     <= 1'b0;
			pend_have_q <= 1'b0;
		end else if (cmd.scan_start) begin
			found_q     <= 1'b0;
			pend_have_q <= 1'b0;
		end else begin
			if (ready_s1 && (!found_q || key_s1 < best_key_q)) begin
				found_q <= 1'b1;
			end
			if (pend_s1) begin
				pend_have_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && (!found_q || key_s1 < best_key_q)) begin
			best_key_q   <= key_s1;
			best_idx_q   <= idx_s1;
			best_burst_q <= burst_s1;
		end
		if (pend_s1 && (!pend_have_q || arr_s1 < pend_min_q)) begin
			pend_min_q <= arr_s1;
		end
	end

	// Table fill, done flags, time and result count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			emitted_q <= '0;
			time_q    <= '0;
			done_q    <= '0;
		end else begin
			if (cmd.load && (count_q < CNT_W'(MAX_JOBS))) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.finish) begin
				count_q <= '0;
			end
			if (cmd.start_set) begin
				time_q    <= '0;
				emitted_q <= '0;
				done_q    <= '0;
			end else if (cmd.jump) begin
				time_q <= TIME_W'(pend_min_q);
			end else if (cmd.emit) begin
				time_q             <= time_q + TIME_W'(best_burst_q);
				emitted_q          <= emitted_q + CNT_W'(1);
				done_q[best_idx_q] <= 1'b1;
			end
		end
	end

	// Result register: holds a transaction until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sched_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			sched_valid_q <= 1'b1;
		end else if (!sched_stall) begin
			sched_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			sched_q.start_time <= time_q;
			sched_q.job_id     <= ID_W'(best_idx_q) + ID_W'(1);
			sched_q.run_length <= best_burst_q;
			sched_q.last_entry <= stat.last_emit;
		end
	end

	assign sched_valid = sched_valid_q;
	assign sched       = sched_q;

	assign stat.scan_fin  = scan_fin_q;
	assign stat.found     = found_q;
	assign stat.last_emit = (emitted_q + CNT_W'(1)) == count_q;
	assign stat.out_busy  = sched_valid_q && sched_stall;

`ifndef SYNTHESIS
	a_emit_has_pick: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> found_q)
		else $error("result issued without a chosen job");
	a_emit_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !(sched_valid_q && sched_stall))
		else $error("result register overwritten while stalled");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_JOBS))
		else $error("job table count beyond capacity");
	a_no_load_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !scanning_q && !vld_s1)
		else $error("job loaded during a scan pass");
	a_jump_has_pending: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.jump |-> pend_have_q)
		else $error("time jump with no pending job");
`endif

endmodule

// ===== rtl/core/njs_ctrl.sv =====
// Controller state machine of the job scheduler.
// Depends on njs_pkg; commands njs_datapath and reads its status.
module njs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	input  logic              job_last,
	output logic              job_stall,
	input  njs_pkg::dp_stat_t stat,
	output njs_pkg::ctl_cmd_t cmd
);
	import njs_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		job_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				job_stall = 1'b0;
				if (job_valid) begin
					cmd.load = 1'b1;
					if (job_last) begin
						cmd.start_set  = 1'b1;
						cmd.scan_start = 1'b1;
						state_d        = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (stat.scan_fin) begin
					state_d = stat.found ? ST_EMIT : ST_JUMP;
				end
			end
			ST_JUMP: begin
				cmd.jump       = 1'b1;
				cmd.scan_start = 1'b1;
				state_d        = ST_SCAN;
			end
			ST_EMIT: begin
				if (!stat.out_busy) begin
					cmd.emit = 1'b1;
					if (stat.last_emit) begin
						cmd.finish = 1'b1;
						state_d    = ST_IDLE;
					end else begin
						cmd.scan_start = 1'b1;
						state_d        = ST_SCAN;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/core/nonpreemptive_job_scheduler.sv =====
// Top level of the non-preemptive job scheduler (FCFS, SJF or priority).
// Depends on njs_pkg, njs_ctrl and njs_datapath.

// Jobs arrive one transaction at a time and are numbered 1, 2, 3 in load
// order; up to MAX_JOBS (16) are kept and later ones are dropped, though a
// dropped job's last_job mark still starts the schedule. Jobs are loaded
// one per cycle. Once the marked job is in, the block stalls its input and
// produces one result transaction per loaded job, in schedule order: it
// makes one pass over the job table per result, reading one entry per cycle
// from the table memory; when no job has arrived yet, time first jumps to
// the next arrival and a further pass is made. The result register lets the
// next pass run while a result waits to be taken. The policy code picks the
// key that is minimized, with ties going to the lower job id: 0 arrival
// time, 1 burst length, 2 priority, and the unused code 3 acts as 0. It is
// written through cfg_we and cfg_wdata and must only change while no
// schedule is in progress.
module nonpreemptive_job_scheduler (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_wdata,
	input  logic            job_valid,
	output logic            job_stall,
	input  njs_pkg::job_t   job,
	output logic            sched_valid,
	input  logic            sched_stall,
	output njs_pkg::sched_t sched
);
	import njs_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t stat;

	// The controller sequences loading, scan passes, time jumps and results.
	njs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_last  (job.last_job),
		.job_stall (job_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// The datapath holds the job table, the running minimum and the clock of
	// the schedule, and owns the result register.
	njs_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.job         (job),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.sched_valid (sched_valid),
		.sched_stall (sched_stall),
		.sched       (sched)
	);

endmodule

// ===== tb/njs_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the non-preemptive job scheduler: watches the job, result and
// configuration ports, predicts each schedule and compares it. Depends on njs_pkg.
module njs_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_wdata,
	input  logic             job_valid,
	input  logic             job_stall,
	input  njs_pkg::job_t    job,
	input  logic             sched_valid,
	input  logic             sched_stall,
	input  njs_pkg::sched_t  sched,
	output int unsigned      fail_count,
	output int unsigned      outstanding
);
	import njs_pkg::*;

	logic [ARR_W-1:0]   arrival_tab [MAX_JOBS];
	logic [BURST_W-1:0] burst_tab   [MAX_JOBS];
	logic [PRIO_W-1:0]  prio_tab    [MAX_JOBS];
	bit                 scheduled   [MAX_JOBS];
	int                 n_loaded  = 0;
	logic [1:0]         policy    = POL_FCFS;
	int unsigned        mismatches = 0;
	sched_t             predicted_runs [$];

	function automatic logic [KEY_W-1:0] policy_key(int j);
		case (policy)
			POL_SJF:  return burst_tab[j];
			POL_PRIO: return KEY_W'(prio_tab[j]);
			default:  return arrival_tab[j];
		endcase
	endfunction

	// Lowest key among the jobs that have arrived by now; ties keep the lower id.
	function automatic int first_ready(logic [TIME_W-1:0] now);
		int pick;
		logic [KEY_W-1:0] best;
		pick = -1;
		best = '0;
		for (int j = 0; j < n_loaded; j++) begin
			if (!scheduled[j] && arrival_tab[j] <= now
					&& (pick < 0 || policy_key(j) < best)) begin
				pick = j;
				best = policy_key(j);
			end
		end
		return pick;
	endfunction

	task automatic plan_schedule();
		logic [TIME_W-1:0] now;
		int pick;
		sched_t run;
		scheduled = '{default: 1'b0};
		now = TIME_W'(arrival_tab[0]);
		for (int j = 1; j < n_loaded; j++)
			if (arrival_tab[j] < now)
				now = TIME_W'(arrival_tab[j]);
		for (int e = 0; e < n_loaded; e++) begin
			pick = first_ready(now);
			if (pick < 0) begin
				// Nothing has arrived yet, so time skips to the next arrival.
				now = '1;
				for (int j = 0; j < n_loaded; j++)
					if (!scheduled[j] && arrival_tab[j] < now)
						now = TIME_W'(arrival_tab[j]);
				pick = first_ready(now);
			end
			run.start_time = now;
			run.job_id     = ID_W'(pick + 1);
			run.run_length = burst_tab[pick];
			run.last_entry = (e == n_loaded - 1);
			predicted_runs.push_back(run);
			scheduled[pick] = 1'b1;
			now = now + TIME_W'(burst_tab[pick]);
		end
		n_loaded = 0;
	endtask

	task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
	endtask

	always @(posedge clk) begin
		sched_t want;
		if (arst_n) begin
			if (cfg_we)
				policy = cfg_wdata;
			if (sched_valid && !sched_stall) begin
				if (predicted_runs.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with none expected, job_id %0d start %0d",
							$time, sched.job_id, sched.start_time);
				end else begin
					want = predicted_runs.pop_front();
					if (sched.start_time !== want.start_time)
						note_mismatch("start_time", 32'(want.start_time),
							32'(sched.start_time));
					if (sched.job_id !== want.job_id)
						note_mismatch("job_id", 32'(want.job_id), 32'(sched.job_id));
					if (sched.run_length !== want.run_length)
						note_mismatch("run_length", 32'(want.run_length),
							32'(sched.run_length));
					if (sched.last_entry !== want.last_entry)
						note_mismatch("last_entry", 32'(want.last_entry),
							32'(sched.last_entry));
				end
			end
			if (job_valid && !job_stall) begin
				if (n_loaded < MAX_JOBS) begin
					arrival_tab[n_loaded] = job.arrival_time;
					burst_tab[n_loaded]   = job.burst_length;
					prio_tab[n_loaded]    = job.job_priority;
					n_loaded++;
				end
				if (job.last_job)
					plan_schedule();
			end
		end
		outstanding <= predicted_runs.size();
		fail_count  <= mismatches;
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Top of the scheduler testbench: clock, reset, job stimulus, result stalls, verdict.
// Depends on njs_pkg, nonpreemptive_job_scheduler and njs_checker.
module testbench;
	import njs_pkg::*;

	// The unused policy code, which the block treats as first come first served.
	localparam logic [1:0] POL_SPARE = 2'd3;
	localparam int RANDOM_ITEMS = 100;
	// Cycles allowed after the last result of a set before the block is
	// considered idle, and cycles of quiet at the end of the run.
	localparam int SETTLE = 8;
	localparam int DRAIN  = 2 * MAX_JOBS + 8;
	// Worst case is far below this: even if every item closed a full table,
	// some 2000 results, stretched by random stalls on both sides.
	localparam int unsigned CYCLE_LIMIT = 1000000;

	logic        clk;
	logic        arst_n      = 1'b0;
	logic        cfg_we      = 1'b0;
	logic [1:0]  cfg_wdata   = POL_FCFS;
	logic        job_valid   = 1'b0;
	logic        job_stall;
	job_t        job_in      = '0;
	logic        sched_valid;
	logic        sched_stall = 1'b0;
	sched_t      sched_out;
	// While set, neither side idles: the block sees back-to-back traffic.
	bit          quiet       = 1'b0;
	int unsigned fail_count;
	int unsigned outstanding;
	int unsigned cycles      = 0;

	nonpreemptive_job_scheduler u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.job_valid   (job_valid),
		.job_stall   (job_stall),
		.job         (job_in),
		.sched_valid (sched_valid),
		.sched_stall (sched_stall),
		.sched       (sched_out)
	);

	njs_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.job_valid   (job_valid),
		.job_stall   (job_stall),
		.job         (job_in),
		.sched_valid (sched_valid),
		.sched_stall (sched_stall),
		.sched       (sched_out),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// While quiet is clear, the result side stalls at random with a probability of about 21 percent.
	always @(posedge clk) begin
		sched_stall <= !quiet && ($urandom_range(99) < 21);
	end

	// A run that hangs is caught here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic job_t make_job(int arrival, int burst, int prio, bit last);
		job_t j;
		j.arrival_time = ARR_W'(arrival);
		j.burst_length = BURST_W'(burst);
		j.job_priority = PRIO_W'(prio);
		j.last_job     = last;
		return j;
	endfunction

	// Three flavors of job: tightly clustered arrivals with small keys, so that
	// ties and the waiting queue matter; fully random fields; and arrivals
	// spread over the whole range with short bursts, so that time jumps often.
	function automatic job_t random_job(int unsigned flavor, bit last);
		job_t j;
		case (flavor)
			0: j = make_job($urandom_range(40), $urandom_range(12), $urandom_range(3), last);
			1: j = make_job($urandom, $urandom, $urandom, last);
			default: j = make_job($urandom, $urandom_range(300), $urandom, last);
		endcase
		return j;
	endfunction

	// Offers one job and returns in the time step in which it was accepted.
	// Valid stays high into the next call, so it is never lowered and raised
	// in one step; a stalled transaction keeps its payload.
	task automatic send_job(job_t j);
		while (!quiet && $urandom_range(99) < 21) begin
			job_valid <= 1'b0;
			@(posedge clk);
		end
		job_valid <= 1'b1;
		job_in    <= j;
		do @(posedge clk); while (job_stall);
	endtask

	// The policy may only change with no schedule in flight, so this drains
	// every expected result and lets the block finish its bookkeeping first.
	task automatic set_policy(logic [1:0] code);
		job_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= code;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int unsigned sent;
		int unsigned set_size;
		int unsigned flavor;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. A single job with every field at its maximum.
		set_policy(POL_FCFS);
		send_job(make_job(16'hFFFF, 16'hFFFF, 8'hFF, 1'b1));
		// A zero-length job, then an idle gap: time has to jump to 5000.
		send_job(make_job(300, 0, 0, 1'b0));
		send_job(make_job(0, 7, 9, 1'b0));
		send_job(make_job(5000, 20, 1, 1'b1));

		// Shortest job first with equal bursts, which go to the lower id.
		set_policy(POL_SJF);
		send_job(make_job(0, 50, 3, 1'b0));
		send_job(make_job(10, 5, 3, 1'b0));
		send_job(make_job(10, 5, 2, 1'b1));

		// Priority with a tie and a late arrival at the top of the range.
		set_policy(POL_PRIO);
		send_job(make_job(0, 100, 7, 1'b0));
		send_job(make_job(1, 1, 7, 1'b0));
		send_job(make_job(65535, 3, 0, 1'b1));

		// The unused code behaves as first come first served. Seventeen jobs
		// overflow the table: the last one is dropped, yet its mark still
		// starts the schedule.
		set_policy(POL_SPARE);
		for (int k = 0; k < MAX_JOBS + 1; k++)
			send_job(make_job((k * 37) % 50, k, 255 - k, k == MAX_JOBS));

		// Random part, in job sets. Sets are mostly small; a few overflow the
		// table. The policy changes between some sets.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(2) == 0)
				set_policy(2'($urandom_range(3)));
			quiet    <= (sent >= 30 && sent < 60);
			set_size = ($urandom_range(9) == 0) ? $urandom_range(MAX_JOBS + 1, MAX_JOBS + 4)
				: $urandom_range(1, 6);
			flavor   = $urandom_range(2);
			for (int k = 0; k < set_size; k++)
				send_job(random_job(flavor, k == set_size - 1));
			sent += set_size;
		end
		quiet     <= 1'b0;
		job_valid <= 1'b0;

		// Wait for every predicted result, then a little longer to catch
		// anything extra the block might still put out.
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		if (fail_count == 0 && outstanding == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/njs_pkg.sv
rtl/core/njs_datapath.sv
rtl/core/njs_ctrl.sv
rtl/core/nonpreemptive_job_scheduler.sv
tb/njs_checker.sv
tb/testbench.sv
